/* rtl/scpa_pkg.sv */
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types, constants and the size-class table of the pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int ADDR_W       = 16;
  localparam int NUM_CLASSES  = 128;
  localparam int CLS_W        = 7;
  localparam int HEADER_BYTES = 2;
  localparam int TABLE_LEN    = 100;
  localparam int CB_W         = 28;
  localparam int OFF_W        = 17;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic CFG_ARENA_LIMIT    = 1'b0;
  localparam logic CFG_RESERVED_BYTES = 1'b1;

  // Classified request handed from front to back
  typedef struct packed {
    logic              req_type;
    logic [15:0]       size;
    logic [15:0]       ptr;
    logic [1:0]        alog;
    logic [CLS_W-1:0]  cls;
    logic              bad;
  } req_rec_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_START,
    B_HEAD,
    B_LRD0,
    B_LRD1,
    B_HWR,
    B_WR1,
    B_SRCH,
    B_BWR1,
    B_FRD0,
    B_FRD1,
    B_FHEAD,
    B_FWR1,
    B_DONE
  } back_state_t;

  // Byte size of each class; ascending
  function automatic logic [CB_W-1:0] class_bytes(input logic [CLS_W-1:0] idx);
    logic [CB_W-1:0] v;
    unique case (idx)
      7'd0: v = 28'd8;        7'd1: v = 28'd11;       7'd2: v = 28'd13;
      7'd3: v = 28'd16;       7'd4: v = 28'd17;       7'd5: v = 28'd19;
      7'd6: v = 28'd20;       7'd7: v = 28'd21;       7'd8: v = 28'd22;
      7'd9: v = 28'd23;       7'd10: v = 28'd24;      7'd11: v = 28'd25;
      7'd12: v = 28'd26;      7'd13: v = 28'd27;      7'd14: v = 28'd28;
      7'd15: v = 28'd29;      7'd16: v = 28'd30;      7'd17: v = 28'd31;
      7'd18: v = 28'd32;      7'd19: v = 28'd33;      7'd20: v = 28'd37;
      7'd21: v = 28'd40;      7'd22: v = 28'd41;      7'd23: v = 28'd48;
      7'd24: v = 28'd56;      7'd25: v = 28'd72;      7'd26: v = 28'd74;
      7'd27: v = 28'd75;      7'd28: v = 28'd76;      7'd29: v = 28'd78;
      7'd30: v = 28'd79;      7'd31: v = 28'd80;      7'd32: v = 28'd81;
      7'd33: v = 28'd101;     7'd34: v = 28'd104;     7'd35: v = 28'd109;
      7'd36: v = 28'd113;     7'd37: v = 28'd116;     7'd38: v = 28'd120;
      7'd39: v = 28'd128;     7'd40: v = 28'd131;     7'd41: v = 28'd143;
      7'd42: v = 28'd151;     7'd43: v = 28'd152;     7'd44: v = 28'd153;
      7'd45: v = 28'd196;     7'd46: v = 28'd256;     7'd47: v = 28'd360;
      7'd48: v = 28'd403;     7'd49: v = 28'd404;     7'd50: v = 28'd432;
      7'd51: v = 28'd486;     7'd52: v = 28'd514;     7'd53: v = 28'd548;
      7'd54: v = 28'd578;     7'd55: v = 28'd604;     7'd56: v = 28'd633;
      7'd57: v = 28'd697;     7'd58: v = 28'd743;     7'd59: v = 28'd784;
      7'd60: v = 28'd839;     7'd61: v = 28'd1176;    7'd62: v = 28'd1536;
      7'd63: v = 28'd1666;    7'd64: v = 28'd2056;    7'd65: v = 28'd2168;
      7'd66: v = 28'd2392;    7'd67: v = 28'd2985;    7'd68: v = 28'd3221;
      7'd69: v = 28'd3433;    7'd70: v = 28'd3753;    7'd71: v = 28'd3832;
      7'd72: v = 28'd4104;    7'd73: v = 28'd4280;    7'd74: v = 28'd4696;
      7'd75: v = 28'd4952;    7'd76: v = 28'd5256;    7'd77: v = 28'd5826;
      7'd78: v = 28'd6264;    7'd79: v = 28'd7176;    7'd80: v = 28'd8440;
      7'd81: v = 28'd9096;    7'd82: v = 28'd16392;   7'd83: v = 28'd32780;
      7'd84: v = 28'd50961;   7'd85: v = 28'd63504;   7'd86: v = 28'd65558;
      7'd87: v = 28'd101912;  7'd88: v = 28'd131088;  7'd89: v = 28'd262144;
      7'd90: v = 28'd507976;  7'd91: v = 28'd524296;  7'd92: v = 28'd1048584;
      7'd93: v = 28'd2097152; 7'd94: v = 28'd4194304; 7'd95: v = 28'd8388608;
      7'd96: v = 28'd16777216; 7'd97: v = 28'd33554432;
      7'd98: v = 28'd67108864; 7'd99: v = 28'd134217728;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/scpa_class_search.sv */
// ----------------------------------------------------------------------------
// scpa_class_search
// Binary search for the first class whose size holds a byte count, one
// halving step per cycle; returns TABLE_LEN when no class fits.
// ----------------------------------------------------------------------------
module scpa_class_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [scpa_pkg::OFF_W-1:0]   need,
  output logic                         done,
  output logic [scpa_pkg::CLS_W-1:0]   idx
);

  logic                       active;
  logic [scpa_pkg::CLS_W-1:0] lo;
  logic [scpa_pkg::CLS_W-1:0] hi;
  logic [scpa_pkg::OFF_W-1:0] need_q;
  logic [scpa_pkg::CLS_W:0]   sum;
  logic [scpa_pkg::CLS_W-1:0] mid;
  logic                       fits;

  // Probe the middle of the live range
  always_comb begin
    sum  = {1'b0, lo} + {1'b0, hi};
    mid  = sum[scpa_pkg::CLS_W:1];
    fits = scpa_pkg::class_bytes(mid) >=
           {{(scpa_pkg::CB_W-scpa_pkg::OFF_W){1'b0}}, need_q};
  end

  assign done = active && (lo == hi);
  assign idx  = lo;

  // Narrow the range
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end
    if (start) begin
      lo     <= '0;
      hi     <= scpa_pkg::CLS_W'(scpa_pkg::TABLE_LEN);
      need_q <= need;
    end else if (active && (lo != hi)) begin
      if (fits) begin
        hi <= mid;
      end else begin
        lo <= mid + scpa_pkg::CLS_W'(1);
      end
    end
  end

endmodule

/* rtl/scpa_front.sv */
// ----------------------------------------------------------------------------
// scpa_front
// Accepts requests, picks the alignment and, for allocations, searches the size
// class, then pushes the classified request toward the back end.
// ----------------------------------------------------------------------------
module scpa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                req_type,
  input  logic [15:0]         req_size,
  input  logic [15:0]         block_ptr,
  output logic                q_push,
  output scpa_pkg::req_rec_t  q_wdata,
  input  logic                q_full
);

  scpa_pkg::front_state_t     state, state_next;
  scpa_pkg::req_rec_t         rec, rec_next;
  logic [1:0]                 alog_in;
  logic [scpa_pkg::OFF_W-1:0] need_in;
  logic                       accept;
  logic                       srch_start;
  logic                       srch_done;
  logic [scpa_pkg::CLS_W-1:0] srch_idx;

  assign full    = (state != scpa_pkg::F_IDLE);
  assign accept  = push && !full;
  assign q_wdata = rec;

  // Alignment from size mod 8, and header plus slack
  always_comb begin
    if (req_size[2:0] == 3'd0) begin
      alog_in = 2'd3;
    end else if (req_size[2:0] == 3'd4) begin
      alog_in = 2'd2;
    end else if (!req_size[0]) begin
      alog_in = 2'd1;
    end else begin
      alog_in = 2'd0;
    end
    need_in = {1'b0, req_size} + scpa_pkg::OFF_W'(1) + (scpa_pkg::OFF_W'(1) << alog_in);
  end

  scpa_class_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .need  (need_in),
    .done  (srch_done),
    .idx   (srch_idx)
  );

  // Sequence accept, search, push
  always_comb begin
    state_next = state;
    rec_next   = rec;
    srch_start = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      scpa_pkg::F_IDLE: begin
        if (accept) begin
          rec_next.req_type = req_type;
          rec_next.size     = req_size;
          rec_next.ptr      = block_ptr;
          rec_next.alog     = alog_in;
          rec_next.cls      = '0;
          rec_next.bad      = 1'b0;
          if (req_type == scpa_pkg::REQ_ALLOC) begin
            srch_start = 1'b1;
            state_next = scpa_pkg::F_SEARCH;
          end else begin
            state_next = scpa_pkg::F_PUSH;
          end
        end
      end
      scpa_pkg::F_SEARCH: begin
        if (srch_done) begin
          rec_next.cls = srch_idx;
          rec_next.bad = (rec.size == 16'd0) ||
                         (srch_idx == scpa_pkg::CLS_W'(scpa_pkg::TABLE_LEN));
          state_next   = scpa_pkg::F_PUSH;
        end
      end
      scpa_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = scpa_pkg::F_IDLE;
        end
      end
      default: state_next = scpa_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpa_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
    rec <= rec_next;
  end

endmodule

/* rtl/scpa_queue.sv */
// ----------------------------------------------------------------------------
// scpa_queue
// Two-entry queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module scpa_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scpa_pkg::req_rec_t  wdata,
  output logic                full,
  input  logic                pop,
  output scpa_pkg::req_rec_t  rdata,
  output logic                empty
);

  scpa_pkg::req_rec_t entries [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = entries[rptr];

  // Advance pointers on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
    if (push && !full) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

/* rtl/scpa_back.sv */
// ----------------------------------------------------------------------------
// scpa_back
// Carries out classified requests against the free-list heads and the byte
// arena, holds the configuration and the result register.
// ----------------------------------------------------------------------------
module scpa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  scpa_pkg::req_rec_t  q_rdata,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [16:0]         cfg_data,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status,
  output logic [15:0]         data_ptr,
  output logic [6:0]          size_class,
  output logic                from_free_list,
  output logic [16:0]         bump_offset
);

  localparam int AW = scpa_pkg::ADDR_W;
  localparam int OW = scpa_pkg::OFF_W;
  localparam int CW = scpa_pkg::CLS_W;

  // Memories
  logic [7:0]    arena [scpa_pkg::ARENA_BYTES];
  logic [15:0]   heads [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::NUM_CLASSES-1:0] hvalid;

  logic          a_we;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [7:0]    a_wdata, a_rdata;
  logic          h_we;
  logic [CW-1:0] h_waddr, h_raddr;
  logic [15:0]   h_wdata, h_rdata;
  logic          h_rvalid;
  logic [15:0]   head_val;

  // Control and datapath registers
  scpa_pkg::back_state_t state, state_next;
  scpa_pkg::req_rec_t    rec, rec_next;
  logic [15:0]   head, head_next;
  logic [15:0]   link, link_next;
  logic [15:0]   fpos, fpos_next;
  logic [7:0]    pad, pad_next;
  logic [CW-1:0] fcls, fcls_next;
  logic [OW-1:0] pa, pa_next;
  logic [OW-1:0] used_offset, used_offset_next;
  logic [OW-1:0] arena_limit;
  logic [1:0]    res_status, res_status_next;
  logic [15:0]   res_data, res_data_next;
  logic [CW-1:0] res_cls, res_cls_next;
  logic          res_reuse, res_reuse_next;
  logic          out_valid;
  logic          load;
  logic          h_set;

  // Address arithmetic
  logic [OW-1:0] am1, lim, p, pa_calc, need2, t, f_reuse;
  logic          oom;
  logic          srch_start, srch_done;
  logic [CW-1:0] srch_idx, c2;

  assign head_val = h_rvalid ? h_rdata : 16'd0;
  assign empty    = !out_valid;

  always_comb begin
    am1     = (OW'(1) << rec.alog) - OW'(1);
    lim     = arena_limit[OW-1] ? OW'(scpa_pkg::ARENA_BYTES) : arena_limit;
    oom     = (used_offset > lim) ||
              ({{(scpa_pkg::CB_W-OW){1'b0}}, lim - used_offset} <
               scpa_pkg::class_bytes(rec.cls));
    p       = used_offset + OW'(scpa_pkg::HEADER_BYTES);
    pa_calc = (p + am1) & ~am1;
    need2   = pa_calc + {1'b0, rec.size} - used_offset;
    t       = {1'b0, head} + OW'(1) + (OW'(1) << rec.alog);
    f_reuse = (t & ~am1) - OW'(scpa_pkg::HEADER_BYTES);
    c2      = (srch_idx == CW'(scpa_pkg::TABLE_LEN)) ? rec.cls : srch_idx;
  end

  scpa_class_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .need  (need2),
    .done  (srch_done),
    .idx   (srch_idx)
  );

  // Request sequencer
  always_comb begin
    state_next       = state;
    rec_next         = rec;
    head_next        = head;
    link_next        = link;
    fpos_next        = fpos;
    pad_next         = pad;
    fcls_next        = fcls;
    pa_next          = pa;
    used_offset_next = used_offset;
    res_status_next  = res_status;
    res_data_next    = res_data;
    res_cls_next     = res_cls;
    res_reuse_next   = res_reuse;
    q_pop            = 1'b0;
    a_we             = 1'b0;
    a_waddr          = fpos;
    a_wdata          = 8'd0;
    a_raddr          = fpos;
    h_we             = 1'b0;
    h_set            = 1'b0;
    h_waddr          = rec.cls;
    h_wdata          = link;
    h_raddr          = rec.cls;
    srch_start       = 1'b0;
    load             = 1'b0;
    unique case (state)
      scpa_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          rec_next   = q_rdata;
          state_next = scpa_pkg::B_START;
        end
      end
      scpa_pkg::B_START: begin
        res_status_next = scpa_pkg::ST_OK;
        res_data_next   = 16'd0;
        res_cls_next    = '0;
        res_reuse_next  = 1'b0;
        if (rec.req_type == scpa_pkg::REQ_FREE) begin
          fpos_next = rec.ptr - 16'd2;
          a_raddr   = rec.ptr - 16'd2;
          if (rec.ptr == 16'd0) begin
            state_next = scpa_pkg::B_DONE;
          end else begin
            state_next = scpa_pkg::B_FRD0;
          end
        end else if (rec.bad) begin
          res_status_next = scpa_pkg::ST_BAD;
          state_next      = scpa_pkg::B_DONE;
        end else begin
          h_raddr    = rec.cls;
          state_next = scpa_pkg::B_HEAD;
        end
      end
      scpa_pkg::B_HEAD: begin
        head_next = head_val;
        a_raddr   = head_val;
        if (head_val != 16'd0) begin
          state_next = scpa_pkg::B_LRD0;
        end else if (oom) begin
          res_status_next = scpa_pkg::ST_OOM;
          state_next      = scpa_pkg::B_DONE;
        end else begin
          pa_next    = pa_calc;
          srch_start = 1'b1;
          state_next = scpa_pkg::B_SRCH;
        end
      end
      scpa_pkg::B_LRD0: begin
        link_next[7:0] = a_rdata;
        a_raddr        = head + 16'd1;
        state_next     = scpa_pkg::B_LRD1;
      end
      scpa_pkg::B_LRD1: begin
        link_next[15:8] = a_rdata;
        state_next      = scpa_pkg::B_HWR;
      end
      scpa_pkg::B_HWR: begin
        // Pop the list head and write the padding byte
        h_we       = 1'b1;
        h_set      = 1'b1;
        h_waddr    = rec.cls;
        h_wdata    = link;
        fpos_next  = f_reuse[15:0];
        a_we       = 1'b1;
        a_waddr    = f_reuse[15:0];
        a_wdata    = 8'(f_reuse[15:0] - head);
        state_next = scpa_pkg::B_WR1;
      end
      scpa_pkg::B_WR1: begin
        a_we           = 1'b1;
        a_waddr        = fpos + 16'd1;
        a_wdata        = {1'b0, rec.cls};
        res_data_next  = fpos + 16'd2;
        res_cls_next   = rec.cls;
        res_reuse_next = 1'b1;
        state_next     = scpa_pkg::B_DONE;
      end
      scpa_pkg::B_SRCH: begin
        if (srch_done) begin
          fcls_next  = c2;
          fpos_next  = 16'(pa - OW'(scpa_pkg::HEADER_BYTES));
          a_we       = 1'b1;
          a_waddr    = 16'(pa - OW'(scpa_pkg::HEADER_BYTES));
          a_wdata    = 8'(pa - p);
          state_next = scpa_pkg::B_BWR1;
        end
      end
      scpa_pkg::B_BWR1: begin
        a_we             = 1'b1;
        a_waddr          = fpos + 16'd1;
        a_wdata          = {1'b0, fcls};
        used_offset_next = used_offset + OW'(scpa_pkg::class_bytes(fcls));
        res_data_next    = pa[15:0];
        res_cls_next     = fcls;
        state_next       = scpa_pkg::B_DONE;
      end
      scpa_pkg::B_FRD0: begin
        pad_next   = a_rdata;
        a_raddr    = fpos + 16'd1;
        state_next = scpa_pkg::B_FRD1;
      end
      scpa_pkg::B_FRD1: begin
        head_next = fpos - {8'd0, pad};
        fcls_next = a_rdata[CW-1:0];
        h_raddr   = a_rdata[CW-1:0];
        if (!a_rdata[7] && ((fpos - {8'd0, pad}) != 16'd0)) begin
          state_next = scpa_pkg::B_FHEAD;
        end else begin
          state_next = scpa_pkg::B_DONE;
        end
      end
      scpa_pkg::B_FHEAD: begin
        // Link the block to the old head
        link_next  = head_val;
        a_we       = 1'b1;
        a_waddr    = head;
        a_wdata    = head_val[7:0];
        state_next = scpa_pkg::B_FWR1;
      end
      scpa_pkg::B_FWR1: begin
        a_we         = 1'b1;
        a_waddr      = head + 16'd1;
        a_wdata      = link[15:8];
        h_we         = 1'b1;
        h_set        = 1'b1;
        h_waddr      = fcls;
        h_wdata      = head;
        res_cls_next = fcls;
        state_next   = scpa_pkg::B_DONE;
      end
      scpa_pkg::B_DONE: begin
        if (!out_valid) begin
          load       = 1'b1;
          state_next = scpa_pkg::B_IDLE;
        end
      end
      default: state_next = scpa_pkg::B_IDLE;
    endcase
  end

  // Arena and head memories, registered reads
  always_ff @(posedge clk) begin
    if (a_we) begin
      arena[a_waddr] <= a_wdata;
    end
    a_rdata <= arena[a_raddr];
    if (h_we) begin
      heads[h_waddr] <= h_wdata;
    end
    h_rdata  <= heads[h_raddr];
    h_rvalid <= hvalid[h_raddr];
  end

  // Control state, configuration and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= scpa_pkg::B_IDLE;
      hvalid      <= '0;
      used_offset <= OW'(24);
      arena_limit <= OW'(scpa_pkg::ARENA_BYTES);
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && !pop) || load;
      // Restart the pool on a reserved-bytes write
      if (cfg_valid && (cfg_index == scpa_pkg::CFG_RESERVED_BYTES)) begin
        used_offset <= {9'd0, cfg_data[7:0]};
        hvalid      <= '0;
      end else begin
        used_offset <= used_offset_next;
        if (h_set) begin
          hvalid[h_waddr] <= 1'b1;
        end
      end
      if (cfg_valid && (cfg_index == scpa_pkg::CFG_ARENA_LIMIT)) begin
        arena_limit <= cfg_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rec        <= rec_next;
    head       <= head_next;
    link       <= link_next;
    fpos       <= fpos_next;
    pad        <= pad_next;
    fcls       <= fcls_next;
    pa         <= pa_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_cls    <= res_cls_next;
    res_reuse  <= res_reuse_next;
    if (load) begin
      status         <= res_status;
      data_ptr       <= res_data;
      size_class     <= res_cls;
      from_free_list <= res_reuse;
      bump_offset    <= used_offset;
    end
  end

endmodule

/* rtl/size_class_pool_allocator_core.sv */
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core
// Size-class pool allocator: front end classifies requests, back end runs
// them against the free-list heads and the byte arena.
// ----------------------------------------------------------------------------
// Timing: a null free is fastest and a bump allocation slowest, as it runs the
//   class search (6 or 7 halving steps) in the front and again in the back for
//   the bump block, and the arena port moves one byte per cycle.
// Overlap: the front classifies the next request while the back works.
// Reset: free lists empty, used offset 24, arena limit 65536; arena contents
//   undefined until written.
module size_class_pool_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [15:0] req_size,
  input  logic [15:0] block_ptr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [15:0] data_ptr,
  output logic [6:0]  size_class,
  output logic        from_free_list,
  output logic [16:0] bump_offset
);

  logic               q_push, q_full, q_pop, q_empty;
  scpa_pkg::req_rec_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  scpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .req_size  (req_size),
    .block_ptr (block_ptr),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  scpa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  scpa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_rdata        (q_rdata),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .data_ptr       (data_ptr),
    .size_class     (size_class),
    .from_free_list (from_free_list),
    .bump_offset    (bump_offset)
  );

endmodule
